### hdl/trss_pkg.sv
// Shared types and constants for the three-rotor step-and-substitute core.
// No dependencies; used by trss_tables and three_rotor_step_and_substitute_core.
package trss_pkg;

  localparam int LETTER_W    = 5;
  localparam int ROTOR_W     = 2;
  localparam int ROTOR_COUNT = 3;

  localparam logic [ROTOR_W-1:0] ROTOR_SLOW   = 2'd0;
  localparam logic [ROTOR_W-1:0] ROTOR_MIDDLE = 2'd1;
  localparam logic [ROTOR_W-1:0] ROTOR_FAST   = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_NOTCH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_NOTCH = 1'b1;

  typedef enum logic [1:0] {
    FUNC_FWD  = 2'd0,
    FUNC_BWD  = 2'd1,
    FUNC_LOAD = 2'd2,
    FUNC_SET  = 2'd3
  } func_e;

  // Access requests to the wiring and inverse tables for one cycle.
  typedef struct packed {
    logic                wr_en;
    logic [ROTOR_W-1:0]  wr_rotor;
    logic [LETTER_W-1:0] wr_pos;
    logic [LETTER_W-1:0] wr_val;
    logic                wir_rd_en;
    logic [ROTOR_W-1:0]  wir_rd_rotor;
    logic [LETTER_W-1:0] wir_rd_idx;
    logic                inv_rd_en;
    logic [ROTOR_W-1:0]  inv_rd_rotor;
    logic [LETTER_W-1:0] inv_rd_idx;
  } tbl_req_t;

endpackage

### hdl/three_rotor_step_and_substitute_core.sv
// Three-rotor step-and-substitute core: top level.
// A forward beat reads the wiring tables and a backward beat the inverse tables, as a chain
// of dependent reads. Load and set are done in the sequencer's idle state. A new beat
// starts only after the last one reaches the output register; the input holding register
// can accept one more request meanwhile. Reset clears offsets, notches and all handshake
// state; table contents are undefined until loaded.
module three_rotor_step_and_substitute_core #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic [trss_pkg::LETTER_W-1:0]  letter_in_i,
  input  logic [trss_pkg::ROTOR_W-1:0]   rotor_select_i,
  input  logic [trss_pkg::LETTER_W-1:0]  position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [trss_pkg::LETTER_W-1:0]  letter_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [trss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [trss_pkg::LETTER_W-1:0]  cfg_data_i
);

  localparam int LW = trss_pkg::LETTER_W;
  localparam int LutDepth = 2 ** LW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD_NF,
    ST_FWD_PF,
    ST_FWD_NM,
    ST_FWD_PM,
    ST_FWD_PS,
    ST_BWD_1,
    ST_BWD_2,
    ST_BWD_3
  } state_e;

  // letter mod alphabet size, for raw 5-bit inputs
  logic [LW-1:0] wrap_lut [LutDepth];
  for (genvar g = 0; g < LutDepth; g++) begin : g_wrap
    assign wrap_lut[g] = LW'(g % ALPHABET_SIZE);
  end

  function automatic logic [LW-1:0] add_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LW+1)'(ALPHABET_SIZE)) begin
      s = s - (LW+1)'(ALPHABET_SIZE);
    end
    return s[LW-1:0];
  endfunction

  function automatic logic [LW-1:0] sub_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
    logic [LW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (LW+1)'(ALPHABET_SIZE) - {1'b0, b};
    end
    return s[LW-1:0];
  endfunction

  // input holding register
  logic                          hold_valid_q;
  trss_pkg::func_e               hold_func_q;
  logic [LW-1:0]                 hold_letter_q;
  logic [trss_pkg::ROTOR_W-1:0]  hold_sel_q;
  logic [LW-1:0]                 hold_pos_q;
  logic                          take;
  logic                          in_accept;

  // sequencer
  state_e        st_q, st_d;
  logic [LW-1:0] x_q, x_d;
  logic          step_q, step_d;
  logic [LW-1:0] off_q [trss_pkg::ROTOR_COUNT];
  logic [LW-1:0] off_d [trss_pkg::ROTOR_COUNT];
  logic          out_valid_q, out_valid_d;
  logic [LW-1:0] out_letter_q, out_letter_d;
  logic [LW-1:0] fast_notch_q, middle_notch_q;

  trss_pkg::tbl_req_t req;
  logic [LW-1:0]      wir_rd;
  logic [LW-1:0]      inv_rd;
  logic [LW-1:0]      hold_wl;
  logic [LW-1:0]      hold_wp;
  logic               sel_ok;
  logic               pos_ok;
  logic               out_free;

  assign in_stall_o  = hold_valid_q & ~take;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign hold_wl  = wrap_lut[hold_letter_q];
  assign hold_wp  = wrap_lut[hold_pos_q];
  assign sel_ok   = (hold_sel_q != 2'd3);
  assign pos_ok   = ({1'b0, hold_pos_q} < (LW+1)'(ALPHABET_SIZE));
  assign out_free = ~out_valid_q | ~out_stall_i;

  trss_tables #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_tables (
    .clk_i   (clk_i),
    .req_i   (req),
    .wir_rd_o(wir_rd),
    .inv_rd_o(inv_rd)
  );

  always_comb begin
    logic [LW-1:0] f1;
    st_d         = st_q;
    x_d          = x_q;
    step_d       = step_q;
    off_d        = off_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_letter_d = out_letter_q;
    take         = 1'b0;
    req          = '0;
    f1           = add_mod(off_q[trss_pkg::ROTOR_FAST], LW'(1));
    unique case (st_q)
      ST_IDLE: begin
        if (hold_valid_q) begin
          take = 1'b1;
          unique case (hold_func_q)
            trss_pkg::FUNC_FWD: begin
              // fast rotor steps first; fetch its new first letter
              off_d[trss_pkg::ROTOR_FAST] = f1;
              req.wir_rd_en    = 1'b1;
              req.wir_rd_rotor = trss_pkg::ROTOR_FAST;
              req.wir_rd_idx   = f1;
              x_d              = hold_wl;
              st_d             = ST_FWD_NF;
            end
            trss_pkg::FUNC_BWD: begin
              req.inv_rd_en    = 1'b1;
              req.inv_rd_rotor = trss_pkg::ROTOR_SLOW;
              req.inv_rd_idx   = hold_wl;
              st_d             = ST_BWD_1;
            end
            trss_pkg::FUNC_LOAD: begin
              if (sel_ok && pos_ok) begin
                req.wr_en    = 1'b1;
                req.wr_rotor = hold_sel_q;
                req.wr_pos   = hold_pos_q;
                req.wr_val   = hold_wl;
              end
            end
            trss_pkg::FUNC_SET: begin
              if (sel_ok) begin
                off_d[hold_sel_q] = hold_wp;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FWD_NF: begin
        step_d = (wir_rd == fast_notch_q);
        if (wir_rd == fast_notch_q) begin
          off_d[trss_pkg::ROTOR_MIDDLE] = add_mod(off_q[trss_pkg::ROTOR_MIDDLE], LW'(1));
        end
        req.wir_rd_en    = 1'b1;
        req.wir_rd_rotor = trss_pkg::ROTOR_FAST;
        req.wir_rd_idx   = add_mod(x_q, off_q[trss_pkg::ROTOR_FAST]);
        st_d             = ST_FWD_PF;
      end
      ST_FWD_PF: begin
        x_d           = wir_rd;
        req.wir_rd_en = 1'b1;
        req.wir_rd_rotor = trss_pkg::ROTOR_MIDDLE;
        if (step_q) begin
          // middle rotor just stepped: its first letter decides the slow step
          req.wir_rd_idx = off_q[trss_pkg::ROTOR_MIDDLE];
          st_d           = ST_FWD_NM;
        end else begin
          req.wir_rd_idx = add_mod(wir_rd, off_q[trss_pkg::ROTOR_MIDDLE]);
          st_d           = ST_FWD_PM;
        end
      end
      ST_FWD_NM: begin
        if (wir_rd == middle_notch_q) begin
          off_d[trss_pkg::ROTOR_SLOW] = add_mod(off_q[trss_pkg::ROTOR_SLOW], LW'(1));
        end
        req.wir_rd_en    = 1'b1;
        req.wir_rd_rotor = trss_pkg::ROTOR_MIDDLE;
        req.wir_rd_idx   = add_mod(x_q, off_q[trss_pkg::ROTOR_MIDDLE]);
        st_d             = ST_FWD_PM;
      end
      ST_FWD_PM: begin
        req.wir_rd_en    = 1'b1;
        req.wir_rd_rotor = trss_pkg::ROTOR_SLOW;
        req.wir_rd_idx   = add_mod(wir_rd, off_q[trss_pkg::ROTOR_SLOW]);
        st_d             = ST_FWD_PS;
      end
      ST_FWD_PS: begin
        // read data holds while waiting for the output slot
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_letter_d = wir_rd;
          st_d         = ST_IDLE;
        end
      end
      ST_BWD_1: begin
        req.inv_rd_en    = 1'b1;
        req.inv_rd_rotor = trss_pkg::ROTOR_MIDDLE;
        req.inv_rd_idx   = sub_mod(inv_rd, off_q[trss_pkg::ROTOR_SLOW]);
        st_d             = ST_BWD_2;
      end
      ST_BWD_2: begin
        req.inv_rd_en    = 1'b1;
        req.inv_rd_rotor = trss_pkg::ROTOR_FAST;
        req.inv_rd_idx   = sub_mod(inv_rd, off_q[trss_pkg::ROTOR_MIDDLE]);
        st_d             = ST_BWD_3;
      end
      ST_BWD_3: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_letter_d = sub_mod(inv_rd, off_q[trss_pkg::ROTOR_FAST]);
          st_d         = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      step_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
      for (int r = 0; r < trss_pkg::ROTOR_COUNT; r++) begin
        off_q[r] <= '0;
      end
      fast_notch_q   <= '0;
      middle_notch_q <= '0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      off_q       <= off_d;
      if (in_accept) begin
        hold_valid_q <= 1'b1;
      end else if (take) begin
        hold_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          trss_pkg::CFG_FAST_NOTCH:   fast_notch_q   <= cfg_data_i;
          trss_pkg::CFG_MIDDLE_NOTCH: middle_notch_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    out_letter_q <= out_letter_d;
    if (in_accept) begin
      hold_func_q   <= trss_pkg::func_e'(func_i);
      hold_letter_q <= letter_in_i;
      hold_sel_q    <= rotor_select_i;
      hold_pos_q    <= position_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign letter_out_o = out_letter_q;

endmodule

### hdl/trss_tables.sv
// Wiring and inverse tables of all rotors: one synchronous memory of each kind.
// Depends on trss_pkg. Read data is registered and appears in the cycle after the read request.
module trss_tables #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk_i,
  input  trss_pkg::tbl_req_t            req_i,
  output logic [trss_pkg::LETTER_W-1:0] wir_rd_o,
  output logic [trss_pkg::LETTER_W-1:0] inv_rd_o
);

  localparam int Depth = trss_pkg::ROTOR_COUNT * ALPHABET_SIZE;
  localparam int AddrW = $clog2(Depth);

  logic [trss_pkg::LETTER_W-1:0] wir_mem [Depth];
  logic [trss_pkg::LETTER_W-1:0] inv_mem [Depth];
  logic [trss_pkg::LETTER_W-1:0] wir_rd_q;
  logic [trss_pkg::LETTER_W-1:0] inv_rd_q;

  function automatic logic [AddrW-1:0] tbl_addr(input logic [trss_pkg::ROTOR_W-1:0]  rotor,
                                                input logic [trss_pkg::LETTER_W-1:0] idx);
    logic [AddrW-1:0] base;
    base = AddrW'(rotor) * AddrW'(ALPHABET_SIZE);
    return base + AddrW'(idx);
  endfunction

  // Loading wiring[r][p] = v also keeps inverse[r][v] = p.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      wir_mem[tbl_addr(req_i.wr_rotor, req_i.wr_pos)] <= req_i.wr_val;
      inv_mem[tbl_addr(req_i.wr_rotor, req_i.wr_val)] <= req_i.wr_pos;
    end
    if (req_i.wir_rd_en) begin
      wir_rd_q <= wir_mem[tbl_addr(req_i.wir_rd_rotor, req_i.wir_rd_idx)];
    end
    if (req_i.inv_rd_en) begin
      inv_rd_q <= inv_mem[tbl_addr(req_i.inv_rd_rotor, req_i.inv_rd_idx)];
    end
  end

  assign wir_rd_o = wir_rd_q;
  assign inv_rd_o = inv_rd_q;

endmodule
